@@ sv/voxel_grid_first_point_filter_defines.svh @@
// Assertion macros for the voxel grid first-point filter.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef VOXEL_GRID_FIRST_POINT_FILTER_DEFINES_SVH
`define VOXEL_GRID_FIRST_POINT_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VGF_ASSERT_IMP(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("voxel filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VGF_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("voxel filter assertion failed");

`endif

@@ sv/vgf_pkg.sv @@
// Shared types and constants of the voxel grid first-point filter.
// Used by every module of the block but vgf_ram; depends on nothing.
package vgf_pkg;

   localparam int DEF_TABLE_DEPTH = 4096;
   localparam int DEF_PROBE_LIMIT = 8;

   localparam int COORD_W = 32;
   localparam int INV_W   = 24;
   localparam int FRAC_W  = 32;
   localparam int PROD_W  = COORD_W + INV_W + 1;
   localparam int KEY_W   = 24;
   localparam int PRIME_W = 27;
   localparam int HASH_W  = 64;
   localparam int HOME_STEP_BITS = 4;

   localparam logic [INV_W-1:0]   INV_RESET = 24'd131072;
   localparam logic [PRIME_W-1:0] PRIME_X   = 27'd73856093;
   localparam logic [PRIME_W-1:0] PRIME_Y   = 27'd19349663;
   localparam logic [PRIME_W-1:0] PRIME_Z   = 27'd83492791;

   typedef enum logic {
      REQ_POINT = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [KEY_W-1:0] kx;
      logic [KEY_W-1:0] ky;
      logic [KEY_W-1:0] kz;
   } key_type;

   typedef struct packed {
      logic    used;
      key_type key;
   } slot_type;

endpackage

@@ sv/vgf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the voxel slot table.
module vgf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/vgf_quant.sv @@
// Voxel quantizer and spatial hash: two pipeline stages of three multipliers.
// Depends on vgf_pkg for widths, primes and the key type.
module vgf_quant (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [vgf_pkg::COORD_W-1:0]  point_x,
   input  logic signed [vgf_pkg::COORD_W-1:0]  point_y,
   input  logic signed [vgf_pkg::COORD_W-1:0]  point_z,
   input  logic [vgf_pkg::INV_W-1:0]           inv,
   output logic                                done,
   output vgf_pkg::key_type                    key,
   output logic [vgf_pkg::HASH_W-1:0]          hash
);
   import vgf_pkg::*;

   localparam int HP_W = KEY_W + PRIME_W + 1;

   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic                     stage1_ff;
   key_type                  key_in, key_ff;
   logic signed [HP_W-1:0]   hx, hy, hz;
   logic [HASH_W-1:0]        hash_in, hash_ff;
   logic                     done_ff;

   // Floor of the Q25.32 product is an arithmetic shift by the fraction width.
   always_comb begin
      prod_x_in = $signed(point_x) * $signed({1'b0, inv});
      prod_y_in = $signed(point_y) * $signed({1'b0, inv});
      prod_z_in = $signed(point_z) * $signed({1'b0, inv});
      key_in.kx = prod_x_ff[FRAC_W+KEY_W-1:FRAC_W];
      key_in.ky = prod_y_ff[FRAC_W+KEY_W-1:FRAC_W];
      key_in.kz = prod_z_ff[FRAC_W+KEY_W-1:FRAC_W];
      hx = $signed(key_in.kx) * $signed({1'b0, PRIME_X});
      hy = $signed(key_in.ky) * $signed({1'b0, PRIME_Y});
      hz = $signed(key_in.kz) * $signed({1'b0, PRIME_Z});
      hash_in = {{(HASH_W-HP_W){hx[HP_W-1]}}, hx}
              ^ {{(HASH_W-HP_W){hy[HP_W-1]}}, hy}
              ^ {{(HASH_W-HP_W){hz[HP_W-1]}}, hz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         done_ff   <= stage1_ff;
      end
      if (start) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
      if (stage1_ff) begin
         key_ff  <= key_in;
         hash_ff <= hash_in;
      end
   end

   assign done = done_ff;
   assign key  = key_ff;
   assign hash = hash_ff;

endmodule

@@ sv/vgf_home.sv @@
// Home slot unit: reduces the 64-bit hash modulo the table depth.
// A power-of-two depth is a mask of the low bits; other depths take four bits a step.
module vgf_home #(
   parameter int TABLE_DEPTH = vgf_pkg::DEF_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [vgf_pkg::HASH_W-1:0]     hash,
   output logic                           done,
   output logic [$clog2(TABLE_DEPTH)-1:0] home
);
   import vgf_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   generate
      if ((1 << AW) == TABLE_DEPTH) begin : g_mask
         logic          done_ff;
         logic [AW-1:0] home_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               home_ff <= hash[AW-1:0];
            end
         end

         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_iter
         localparam int            STEPS = HASH_W / HOME_STEP_BITS;
         localparam int            CW    = $clog2(STEPS);
         localparam logic [AW:0]   DEPTH_C = (AW+1)'(TABLE_DEPTH);

         logic              busy_ff, busy_in;
         logic              done_ff, done_in;
         logic [CW-1:0]     cnt_ff, cnt_in;
         logic [HASH_W-1:0] shift_ff, shift_in;
         logic [AW:0]       rem_ff, rem_in;

         always_comb begin
            logic [AW:0] r;
            r        = rem_ff;
            busy_in  = busy_ff;
            done_in  = 1'b0;
            cnt_in   = cnt_ff;
            shift_in = shift_ff;
            rem_in   = rem_ff;
            if (start) begin
               busy_in  = 1'b1;
               cnt_in   = '0;
               shift_in = hash;
               rem_in   = '0;
            end else if (busy_ff) begin
               for (int j = 0; j < HOME_STEP_BITS; j++) begin
                  r = {r[AW-1:0], shift_ff[HASH_W-1-j]};
                  if (r >= DEPTH_C) begin
                     r = r - DEPTH_C;
                  end
               end
               rem_in   = r;
               shift_in = shift_ff << HOME_STEP_BITS;
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff == CW'(STEPS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               busy_ff <= busy_in;
               done_ff <= done_in;
            end
            cnt_ff   <= cnt_in;
            shift_ff <= shift_in;
            rem_ff   <= rem_in;
         end

         assign done = done_ff;
         assign home = rem_ff[AW-1:0];
      end
   endgenerate

endmodule

@@ sv/voxel_grid_first_point_filter.sv @@
// Channel  Ports                                     Word
// req      req_valid / req_stall                     req_type, req_point_x/y/z
// rsp      rsp_valid / rsp_stall                     rsp_kept_x/y/z, rsp_table_overflow
// csr      csr_wr_en                                 csr_wr_data (inverse voxel size)
//
// A point passes the two multiplier stages, the home slot unit and one table read per probe
// before its result is registered. A depth that is not a power of two is reduced in the home
// slot unit by repeated shift and subtract.
// With a zero inverse size a point skips the lookup; a clear request sweeps the whole slot table.
// After reset the whole slot table is swept before the first word is taken.
// A stalled result holds in the output register; the block then waits to load the next one.
`include "voxel_grid_first_point_filter_defines.svh"

module voxel_grid_first_point_filter #(
   parameter int TABLE_DEPTH = vgf_pkg::DEF_TABLE_DEPTH,
   parameter int PROBE_LIMIT = vgf_pkg::DEF_PROBE_LIMIT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_kept_x,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_kept_y,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_kept_z,
   output logic                                rsp_table_overflow,
   input  logic                                csr_wr_en,
   input  logic [vgf_pkg::INV_W-1:0]           csr_wr_data
);
   import vgf_pkg::*;

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int PW     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WAIT,
      S_PROBE,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]          probe_addr_ff, probe_addr_in;
   logic [PW-1:0]          probe_cnt_ff, probe_cnt_in;
   logic signed [COORD_W-1:0] pnt_x_ff, pnt_x_in, pnt_y_ff, pnt_y_in, pnt_z_ff, pnt_z_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic [INV_W-1:0]       inv_ff;

   logic                   accept;
   logic                   quant_start;
   logic                   quant_done;
   key_type                quant_key;
   logic [HASH_W-1:0]      quant_hash;
   logic                   home_done;
   logic [AW-1:0]          home;
   logic [AW-1:0]          next_addr;
   logic                   out_free;
   logic                   go_emit;
   slot_type               rd_slot;
   slot_type               wr_slot;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [AW-1:0]          ram_rd_addr;
   logic [SLOT_W-1:0]      ram_rd_data;

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign quant_start = accept && (req_kind_type'(req_type) == REQ_POINT) && (inv_ff != '0);
   assign next_addr   = (probe_addr_ff == AW'(TABLE_DEPTH - 1)) ? '0 : probe_addr_ff + 1'b1;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rd_slot     = slot_type'(ram_rd_data);
   assign ram_rd_addr = (state_ff == S_WAIT) ? home : next_addr;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = probe_addr_ff;
      wr_slot     = '0;
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
      end else if (state_ff == S_PROBE && !rd_slot.used) begin
         ram_wr_en    = 1'b1;
         wr_slot.used = 1'b1;
         wr_slot.key  = quant_key;
      end
   end

   vgf_quant u_quant (
      .clock   (clock),
      .reset   (reset),
      .start   (quant_start),
      .point_x (req_point_x),
      .point_y (req_point_y),
      .point_z (req_point_z),
      .inv     (inv_ff),
      .done    (quant_done),
      .key     (quant_key),
      .hash    (quant_hash)
   );

   vgf_home #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (quant_done),
      .hash  (quant_hash),
      .done  (home_done),
      .home  (home)
   );

   vgf_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (SLOT_W'(wr_slot)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      probe_addr_in = probe_addr_ff;
      probe_cnt_in  = probe_cnt_ff;
      pnt_x_in      = pnt_x_ff;
      pnt_y_in      = pnt_y_ff;
      pnt_z_in      = pnt_z_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      go_emit       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(TABLE_DEPTH - 1)) begin
               clr_cnt_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               pnt_x_in = req_point_x;
               pnt_y_in = req_point_y;
               pnt_z_in = req_point_z;
               ovf_in   = 1'b0;
               if (req_kind_type'(req_type) == REQ_CLEAR) begin
                  clr_cnt_in = '0;
                  state_in   = S_CLEAR;
               end else if (inv_ff == '0) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (home_done) begin
               probe_addr_in = home;
               probe_cnt_in  = '0;
               state_in      = S_PROBE;
            end
         end
         S_PROBE: begin
            if (!rd_slot.used) begin
               ovf_in  = 1'b0;
               go_emit = 1'b1;
            end else if (rd_slot.key == quant_key) begin
               state_in = S_IDLE;
            end else if (probe_cnt_ff == PW'(PROBE_LIMIT - 1)) begin
               ovf_in  = 1'b1;
               go_emit = 1'b1;
            end else begin
               probe_cnt_in  = probe_cnt_ff + 1'b1;
               probe_addr_in = next_addr;
            end
         end
         S_EMIT: begin
            go_emit = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (go_emit) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = pnt_x_ff;
            rsp_y_in     = pnt_y_ff;
            rsp_z_in     = pnt_z_ff;
            rsp_ovf_in   = ovf_in;
            state_in     = S_IDLE;
         end else begin
            state_in = S_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      probe_addr_ff <= probe_addr_in;
      probe_cnt_ff  <= probe_cnt_in;
      pnt_x_ff      <= pnt_x_in;
      pnt_y_ff      <= pnt_y_in;
      pnt_z_ff      <= pnt_z_in;
      ovf_ff        <= ovf_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= INV_RESET;
      end else if (csr_wr_en) begin
         inv_ff <= csr_wr_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kept_x         = rsp_x_ff;
   assign rsp_kept_y         = rsp_y_ff;
   assign rsp_kept_z         = rsp_z_ff;
   assign rsp_table_overflow = rsp_ovf_ff;

   `VGF_ASSERT_IMP(a_home_only_when_waiting, clock, reset, home_done, state_ff == S_WAIT)
   `VGF_ASSERT_IMP(a_probe_addr_in_table, clock, reset, state_ff == S_PROBE,
                   probe_addr_ff <= AW'(TABLE_DEPTH - 1))
   `VGF_ASSERT_IMP(a_result_from_lookup, clock, reset, $rose(rsp_valid_ff),
                   $past(state_ff) == S_PROBE || $past(state_ff) == S_EMIT)
   `VGF_ASSERT_NEXT(a_clear_starts_sweep, clock, reset,
                    accept && req_kind_type'(req_type) == REQ_CLEAR,
                    state_ff == S_CLEAR && clr_cnt_ff == '0)

endmodule
